>>> hw/rtl/npcp_pkg.sv
// ----------------------------------------------------------------------------
// npcp_pkg
// shared types, widths and helpers for the near plane clip and project block
// ----------------------------------------------------------------------------
`default_nettype none

package npcp_pkg;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int EYE_BITS   = 15;

   localparam logic [EYE_BITS-1:0] EYE_RESET = EYE_BITS'(1000);

   // magnitude width for every operand of the shared unit
   localparam int OPW = ((COORD_BITS > EYE_BITS + FRAC_BITS) ?
                         COORD_BITS : EYE_BITS + FRAC_BITS) + 1;
   localparam int WW    = OPW + 1;
   localparam int QW    = 2 * OPW;
   localparam int CNT_W = $clog2(QW + 1);

   localparam logic [QW-1:0] SAT_MAG = QW'(1) << (COORD_BITS - 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [WW-1:0]         wide_type;

   localparam coord_type CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      coord_type vertex_x;
      coord_type vertex_y;
      coord_type vertex_z;
      logic      last_vertex;
   } req_type;

   typedef struct packed {
      coord_type screen_x;
      coord_type screen_y;
      logic      vertex_valid;
      logic      polygon_end;
      logic      overflow;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   function automatic wide_type widen(input coord_type c);
      return {{(WW-COORD_BITS){c[COORD_BITS-1]}}, c};
   endfunction

   function automatic logic [OPW-1:0] mag(input wide_type v);
      wide_type n;
      n = -v;
      return v[WW-1] ? n[OPW-1:0] : v[OPW-1:0];
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/npcp_muldiv.sv
// ----------------------------------------------------------------------------
// npcp_muldiv
// iterative unsigned (a * b) / d: shift-add multiply then restoring divide
// ----------------------------------------------------------------------------
`default_nettype none

module npcp_muldiv (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [npcp_pkg::OPW-1:0]   a,
   input  wire logic [npcp_pkg::OPW-1:0]   b,
   input  wire logic [npcp_pkg::OPW-1:0]   d,
   output logic                            done,
   output logic [npcp_pkg::QW-1:0]         q
);

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_MUL  = 2'd1;
   localparam logic [1:0] M_DIV  = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [npcp_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [npcp_pkg::QW-1:0]      num_ff, num_in;
   logic [npcp_pkg::QW-1:0]      mcand_ff, mcand_in;
   logic [npcp_pkg::OPW-1:0]     mplier_ff, mplier_in;
   logic [npcp_pkg::OPW-1:0]     div_ff, div_in;
   logic [npcp_pkg::OPW:0]       rem_ff, rem_in;
   logic                         done_ff, done_in;
   logic [npcp_pkg::OPW:0]       rem_sh;
   logic [npcp_pkg::OPW:0]       diff;
   logic                         ge;

   assign rem_sh = {rem_ff[npcp_pkg::OPW-1:0], num_ff[npcp_pkg::QW-1]};
   assign diff   = rem_sh - {1'b0, div_ff};
   assign ge     = rem_sh >= {1'b0, div_ff};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         M_IDLE: begin
            if (start) begin
               num_in    = '0;
               mcand_in  = npcp_pkg::QW'(a);
               mplier_in = b;
               div_in    = d;
               cnt_in    = '0;
               state_in  = M_MUL;
            end
         end
         M_MUL: begin
            if (mplier_ff[0]) begin
               num_in = num_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == npcp_pkg::CNT_W'(npcp_pkg::OPW - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = M_DIV;
            end
         end
         M_DIV: begin
            rem_in = ge ? diff : rem_sh;
            num_in = {num_ff[npcp_pkg::QW-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == npcp_pkg::CNT_W'(npcp_pkg::QW - 1)) begin
               done_in  = 1'b1;
               state_in = M_IDLE;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      num_ff    <= num_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
   end

   assign done = done_ff;
   assign q    = num_ff;

endmodule

`default_nettype wire

>>> hw/rtl/near_plane_clip_and_project.sv
// ----------------------------------------------------------------------------
// near_plane_clip_and_project
// clips polygon edges against z >= 0 and projects kept points by r / (r - z)
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | npcp_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall  | npcp_pkg::rsp_type
//   csr     | in        | csr_valid/csr_ready  | eye distance, 15 bits
//
// one vertex transaction runs 0 to 3 points through the shared multiply-divide
// unit; an edge crossing costs up to 4 divisions, a kept vertex up to 2, as
// the projection divisions are skipped when z >= r
// req is stalled until every result of the vertex has been taken
// each result waits in the rsp register while rsp_stall is high
// synchronous reset clears the open polygon and sets eye distance to 1000
// ----------------------------------------------------------------------------
`default_nettype none

module near_plane_clip_and_project (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire npcp_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output npcp_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [npcp_pkg::EYE_BITS-1:0] csr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PICK = 3'd1;
   localparam logic [2:0] S_CX   = 3'd2;
   localparam logic [2:0] S_CY   = 3'd3;
   localparam logic [2:0] S_PX   = 3'd4;
   localparam logic [2:0] S_PY   = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   localparam int CW = npcp_pkg::COORD_BITS;

   logic [2:0]                      state_ff, state_in;
   logic [2:0]                      pend_ff, pend_in;
   logic                            marker_ff, marker_in;
   logic                            last_ff, last_in;
   logic                            issued_ff, issued_in;
   logic                            inside_ff, inside_in;
   logic                            emitted_ff, emitted_in;
   logic                            ovf_ff, ovf_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [npcp_pkg::EYE_BITS-1:0]   eye_ff, eye_in;
   npcp_pkg::point_type             first_ff, first_in;
   npcp_pkg::point_type             prev_ff, prev_in;
   npcp_pkg::point_type             old_ff, old_in;
   npcp_pkg::point_type             cur_ff, cur_in;
   npcp_pkg::point_type             p_ff, p_in;
   npcp_pkg::point_type             q_ff, q_in;
   npcp_pkg::point_type             pt_ff, pt_in;
   npcp_pkg::coord_type             resx_ff, resx_in;
   npcp_pkg::rsp_type               rsp_ff, rsp_in;

   logic                            req_accept;
   npcp_pkg::point_type             v;
   logic                            v_first, v_in_view, emitted_eff;
   logic                            c1, c2;
   npcp_pkg::point_type             first_eff;

   npcp_pkg::wide_type              r_w, pc_w, qc_w, pz_w, qz_w, dc_w, dz_w;
   npcp_pkg::wide_type              c_w, z_w, rz_w, m_w, cross_w;
   logic                            z_ge;
   logic                            md_start, md_done;
   logic [npcp_pkg::OPW-1:0]        md_a, md_b, md_d;
   logic [npcp_pkg::QW-1:0]         md_q;
   npcp_pkg::coord_type             proj_val, edge_val;
   logic                            proj_ovf;
   logic                            pe;

   assign req_stall  = reset || (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = !reset;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign v.x = req_data.vertex_x;
   assign v.y = req_data.vertex_y;
   assign v.z = req_data.vertex_z;
   assign v_first     = !inside_ff;
   assign v_in_view   = !v.z[CW-1];
   assign emitted_eff = v_first ? 1'b0 : emitted_ff;
   assign first_eff   = v_first ? v : first_ff;
   assign c1 = !v_first && (prev_ff.z[CW-1] != v.z[CW-1]);
   assign c2 = req_data.last_vertex && (first_eff.z[CW-1] != v.z[CW-1]);

   // cross operands
   assign r_w  = $signed(npcp_pkg::WW'({eye_ff, {npcp_pkg::FRAC_BITS{1'b0}}}));
   assign pc_w = npcp_pkg::widen((state_ff == S_CX) ? p_ff.x : p_ff.y);
   assign qc_w = npcp_pkg::widen((state_ff == S_CX) ? q_ff.x : q_ff.y);
   assign pz_w = npcp_pkg::widen(p_ff.z);
   assign qz_w = npcp_pkg::widen(q_ff.z);
   assign dc_w = qc_w - pc_w;
   assign dz_w = pz_w - qz_w;
   assign m_w  = $signed(md_q[npcp_pkg::WW-1:0]);
   assign cross_w = dc_w[npcp_pkg::WW-1] ? (pc_w - m_w) : (pc_w + m_w);
   assign edge_val = cross_w[CW-1:0];

   // projection operands
   assign c_w  = npcp_pkg::widen((state_ff == S_PX) ? pt_ff.x : pt_ff.y);
   assign z_w  = npcp_pkg::widen(pt_ff.z);
   assign rz_w = r_w - z_w;
   assign z_ge = z_w >= r_w;

   always_comb begin
      if (state_ff == S_CX || state_ff == S_CY) begin
         md_a = npcp_pkg::mag(dc_w);
         md_b = npcp_pkg::mag(pz_w);
         md_d = npcp_pkg::mag(dz_w);
      end else begin
         md_a = npcp_pkg::mag(c_w);
         md_b = r_w[npcp_pkg::OPW-1:0];
         md_d = rz_w[npcp_pkg::OPW-1:0];
      end
   end

   always_comb begin
      if (c_w[npcp_pkg::WW-1]) begin
         proj_ovf = md_q > npcp_pkg::SAT_MAG;
         proj_val = proj_ovf ? npcp_pkg::CMIN : -md_q[CW-1:0];
      end else begin
         proj_ovf = md_q >= npcp_pkg::SAT_MAG;
         proj_val = proj_ovf ? npcp_pkg::CMAX : md_q[CW-1:0];
      end
   end

   function automatic npcp_pkg::coord_type clamp(input npcp_pkg::coord_type c);
      priority if (c[CW-1]) begin
         return npcp_pkg::CMIN;
      end else if (c != '0) begin
         return npcp_pkg::CMAX;
      end else begin
         return '0;
      end
   endfunction

   assign pe = last_ff && (pend_ff == 3'b000) && !marker_ff;

   npcp_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .a     (md_a),
      .b     (md_b),
      .d     (md_d),
      .done  (md_done),
      .q     (md_q)
   );

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      marker_in    = marker_ff;
      last_in      = last_ff;
      issued_in    = issued_ff;
      inside_in    = inside_ff;
      emitted_in   = emitted_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      eye_in       = eye_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      old_in       = old_ff;
      cur_in       = cur_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      pt_in        = pt_ff;
      resx_in      = resx_ff;
      rsp_in       = rsp_ff;
      md_start     = 1'b0;

      if (csr_valid) begin
         eye_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               pend_in    = {c2, v_in_view, c1};
               marker_in  = req_data.last_vertex && !(c1 || c2 || v_in_view)
                            && !emitted_eff;
               last_in    = req_data.last_vertex;
               first_in   = first_eff;
               old_in     = prev_ff;
               prev_in    = v;
               cur_in     = v;
               inside_in  = !req_data.last_vertex;
               emitted_in = req_data.last_vertex ? 1'b0 :
                            (emitted_eff || c1 || c2 || v_in_view);
               state_in   = S_PICK;
            end
         end
         S_PICK: begin
            ovf_in = 1'b0;
            priority if (pend_ff[0]) begin
               pend_in[0] = 1'b0;
               p_in       = old_ff;
               q_in       = cur_ff;
               state_in   = S_CX;
            end else if (pend_ff[1]) begin
               pend_in[1] = 1'b0;
               pt_in      = cur_ff;
               state_in   = S_PX;
            end else if (pend_ff[2]) begin
               pend_in[2] = 1'b0;
               p_in       = cur_ff;
               q_in       = first_ff;
               state_in   = S_CX;
            end else if (marker_ff) begin
               marker_in           = 1'b0;
               rsp_in.screen_x     = '0;
               rsp_in.screen_y     = '0;
               rsp_in.vertex_valid = 1'b0;
               rsp_in.polygon_end  = 1'b1;
               rsp_in.overflow     = 1'b0;
               rsp_valid_in        = 1'b1;
               state_in            = S_OUT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_CX, S_CY: begin
            if (!issued_ff) begin
               md_start  = 1'b1;
               issued_in = 1'b1;
            end else if (md_done) begin
               issued_in = 1'b0;
               if (state_ff == S_CX) begin
                  pt_in.x  = edge_val;
                  state_in = S_CY;
               end else begin
                  pt_in.y  = edge_val;
                  pt_in.z  = '0;
                  state_in = S_PX;
               end
            end
         end
         S_PX: begin
            if (z_ge) begin
               rsp_in.screen_x     = clamp(pt_ff.x);
               rsp_in.screen_y     = clamp(pt_ff.y);
               rsp_in.vertex_valid = 1'b1;
               rsp_in.polygon_end  = pe;
               rsp_in.overflow     = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = S_OUT;
            end else if (!issued_ff) begin
               md_start  = 1'b1;
               issued_in = 1'b1;
            end else if (md_done) begin
               issued_in = 1'b0;
               resx_in   = proj_val;
               ovf_in    = proj_ovf;
               state_in  = S_PY;
            end
         end
         S_PY: begin
            if (!issued_ff) begin
               md_start  = 1'b1;
               issued_in = 1'b1;
            end else if (md_done) begin
               issued_in           = 1'b0;
               rsp_in.screen_x     = resx_ff;
               rsp_in.screen_y     = proj_val;
               rsp_in.vertex_valid = 1'b1;
               rsp_in.polygon_end  = pe;
               rsp_in.overflow     = ovf_ff || proj_ovf;
               rsp_valid_in        = 1'b1;
               state_in            = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_PICK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= '0;
         marker_ff    <= 1'b0;
         last_ff      <= 1'b0;
         issued_ff    <= 1'b0;
         inside_ff    <= 1'b0;
         emitted_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         eye_ff       <= npcp_pkg::EYE_RESET;
         first_ff     <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         marker_ff    <= marker_in;
         last_ff      <= last_in;
         issued_ff    <= issued_in;
         inside_ff    <= inside_in;
         emitted_ff   <= emitted_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         eye_ff       <= eye_in;
         first_ff     <= first_in;
         prev_ff      <= prev_in;
      end
      old_ff  <= old_in;
      cur_ff  <= cur_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      pt_ff   <= pt_in;
      resx_ff <= resx_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire
